// ===== src/jswcs_pkg.sv =====
// ----------------------------------------------------------------------------
// jswcs_pkg
// Shared types and constants for the script whitespace and comment stripper.
// ----------------------------------------------------------------------------
`default_nettype none

package jswcs_pkg;

    localparam int QDEPTH = 4;
    localparam int QAW    = 2;
    localparam int QLW    = 3;

    localparam logic [7:0] CH_LF    = 8'h0A;
    localparam logic [7:0] CH_TAB   = 8'h09;
    localparam logic [7:0] CH_CR    = 8'h0D;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_SEMI  = 8'h3B;
    localparam logic [7:0] CH_LBRC  = 8'h7B;
    localparam logic [7:0] CH_RBRC  = 8'h7D;
    localparam logic [7:0] CH_LPAR  = 8'h28;
    localparam logic [7:0] CH_RPAR  = 8'h29;
    localparam logic [7:0] CH_LBRK  = 8'h5B;
    localparam logic [7:0] CH_RBRK  = 8'h5D;
    localparam logic [7:0] CH_COMMA = 8'h2C;
    localparam logic [7:0] CH_DOT   = 8'h2E;
    localparam logic [7:0] CH_DQUOT = 8'h22;
    localparam logic [7:0] CH_SQUOT = 8'h27;
    localparam logic [7:0] CH_BSL   = 8'h5C;
    localparam logic [7:0] CH_SLASH = 8'h2F;

    // Results produced by one input transaction, in stream order.
    typedef struct packed {
        logic [1:0] count;
        logic [7:0] first_chr;
        logic [7:0] second_chr;
    } t_emit;

    typedef struct packed {
        logic           room;
        logic [QLW-1:0] level;
    } t_q_stat;

endpackage

`default_nettype wire

// ===== src/jswcs_core.sv =====
// ----------------------------------------------------------------------------
// jswcs_core
// Scanner state and per-byte decode: up to two kept bytes per transaction.
// ----------------------------------------------------------------------------
`default_nettype none

module jswcs_core
    import jswcs_pkg::*;
(
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       i_fire,
    input  wire logic [7:0] i_byte,
    input  wire logic       i_last,
    output t_emit           o_emit
);

    localparam logic [1:0] MODE_NORMAL  = 2'd0;
    localparam logic [1:0] MODE_STRING  = 2'd1;
    localparam logic [1:0] MODE_TRIM    = 2'd2;
    localparam logic [1:0] MODE_COMMENT = 2'd3;

    logic [1:0] r_mode, n_mode;
    logic [7:0] r_quote, n_quote;
    logic       r_esc, n_esc;
    logic       r_slash, n_slash;

    logic       do_norm;
    logic       emit_slash;
    logic       emit_b;
    logic       tail_slash;
    logic       is_space;
    logic       is_trig;

    always_comb begin
        is_space = i_byte inside {CH_LF, CH_TAB, CH_CR, CH_SPACE};
        is_trig  = i_byte inside {CH_SEMI, CH_LBRC, CH_RBRC, CH_LPAR, CH_RPAR,
                                  CH_LBRK, CH_RBRK, CH_COMMA, CH_DOT};
        n_mode     = r_mode;
        n_quote    = r_quote;
        n_esc      = r_esc;
        n_slash    = r_slash;
        do_norm    = 1'b0;
        emit_slash = 1'b0;
        emit_b     = 1'b0;
        tail_slash = 1'b0;

        if (r_esc) begin
            emit_b = 1'b1;
            n_esc  = 1'b0;
        end else begin
            case (r_mode)
                MODE_STRING: begin
                    emit_b = 1'b1;
                    if (i_byte == CH_BSL) begin
                        n_esc = 1'b1;
                    end else if (i_byte == r_quote) begin
                        n_mode  = MODE_NORMAL;
                        n_quote = 8'h00;
                    end
                end
                MODE_COMMENT: begin
                    if (i_byte == CH_LF) begin
                        n_mode = MODE_TRIM;
                    end
                end
                MODE_TRIM: begin
                    do_norm = !is_space;
                end
                default: begin
                    if (r_slash) begin
                        n_slash = 1'b0;
                        if (i_byte == CH_SLASH) begin
                            n_mode = MODE_COMMENT;
                        end else begin
                            emit_slash = 1'b1;
                            do_norm    = 1'b1;
                        end
                    end else begin
                        do_norm = 1'b1;
                    end
                end
            endcase
        end

        if (do_norm) begin
            if (i_byte == CH_BSL) begin
                emit_b = 1'b1;
                n_esc  = 1'b1;
                n_mode = MODE_NORMAL;
            end else if (i_byte == CH_DQUOT || i_byte == CH_SQUOT) begin
                emit_b  = 1'b1;
                n_quote = i_byte;
                n_mode  = MODE_STRING;
            end else if (i_byte == CH_SLASH) begin
                n_slash = 1'b1;
                n_mode  = MODE_NORMAL;
            end else if (is_trig) begin
                emit_b = 1'b1;
                n_mode = MODE_TRIM;
            end else begin
                emit_b = 1'b1;
                n_mode = MODE_NORMAL;
            end
        end

        if (i_last) begin
            tail_slash = n_slash;
            n_mode     = MODE_NORMAL;
            n_quote    = 8'h00;
            n_esc      = 1'b0;
            n_slash    = 1'b0;
        end

        o_emit.count      = 2'({1'b0, emit_slash}) + 2'({1'b0, emit_b})
                          + 2'({1'b0, tail_slash});
        o_emit.first_chr  = emit_slash ? CH_SLASH : (emit_b ? i_byte : CH_SLASH);
        o_emit.second_chr = (emit_slash && emit_b) ? i_byte : CH_SLASH;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode  <= MODE_NORMAL;
            r_quote <= 8'h00;
            r_esc   <= 1'b0;
            r_slash <= 1'b0;
        end else if (i_fire) begin
            r_mode  <= n_mode;
            r_quote <= n_quote;
            r_esc   <= n_esc;
            r_slash <= n_slash;
        end
    end

endmodule

`default_nettype wire

// ===== src/jswcs_outq.sv =====
// ----------------------------------------------------------------------------
// jswcs_outq
// Result queue: takes up to two bytes per cycle, delivers one per cycle unless stalled.
// ----------------------------------------------------------------------------
`default_nettype none

module jswcs_outq
    import jswcs_pkg::*;
(
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       i_push,
    input  wire t_emit      i_emit,
    output t_q_stat         o_stat,
    output logic            o_valid,
    input  wire logic       i_stall,
    output logic [7:0]      o_out_byte,
    output logic            o_last_of_run
);

    logic [8:0]     r_mem [QDEPTH];
    logic [QAW-1:0] r_wp, n_wp;
    logic [QAW-1:0] r_rp, n_rp;
    logic [QLW-1:0] r_level, n_level;
    logic [1:0]     push_cnt;
    logic           pop;

    assign push_cnt      = i_push ? i_emit.count : 2'd0;
    assign o_valid       = (r_level != '0);
    assign pop           = o_valid && !i_stall;
    assign o_out_byte    = r_mem[r_rp][8:1];
    assign o_last_of_run = r_mem[r_rp][0];
    assign o_stat.room   = (r_level <= QLW'(QDEPTH - 2));
    assign o_stat.level  = r_level;

    always_comb begin
        n_wp    = r_wp + QAW'(push_cnt);
        n_rp    = r_rp + QAW'(pop);
        n_level = r_level + QLW'(push_cnt) - QLW'(pop);
    end

    always_ff @(posedge i_clk) begin
        if (push_cnt != 2'd0) begin
            r_mem[r_wp] <= {i_emit.first_chr, push_cnt == 2'd1};
        end
        if (push_cnt == 2'd2) begin
            r_mem[r_wp + QAW'(1)] <= {i_emit.second_chr, 1'b1};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp    <= '0;
            r_rp    <= '0;
            r_level <= '0;
        end else begin
            r_wp    <= n_wp;
            r_rp    <= n_rp;
            r_level <= n_level;
        end
    end

endmodule

`default_nettype wire

// ===== src/js_whitespace_comment_stripper.sv =====
// ----------------------------------------------------------------------------
// js_whitespace_comment_stripper
// Streaming script minifier: drops line comments and whitespace after
// punctuation, passes strings and escapes through untouched.
//
//   channel | valid   | stall   | payload
//   --------+---------+---------+----------------------------
//   input   | i_valid | o_stall | i_in_byte, i_is_last
//   output  | o_valid | i_stall | o_out_byte, o_last_of_run
//
// One input transaction per cycle while the input is not stalled; a kept byte
// passes the input register, then the result queue, before it is offered.
// A transaction yielding two bytes is delivered one byte at a time; the
// one-byte-per-cycle output, when not stalled, sets the sustained rate under such bursts.
// Synchronous active-low reset clears scanner state and empties the queue.
// Input stalls only while the registered transaction waits for queue room.
// ----------------------------------------------------------------------------
`default_nettype none

module js_whitespace_comment_stripper
    import jswcs_pkg::*;
(
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       i_valid,
    output logic            o_stall,
    input  wire logic [7:0] i_in_byte,
    input  wire logic       i_is_last,
    output logic            o_valid,
    input  wire logic       i_stall,
    output logic [7:0]      o_out_byte,
    output logic            o_last_of_run
);

    logic       r_in_valid;
    logic [7:0] r_in_byte;
    logic       r_in_last;
    logic       in_acc;
    logic       fire;
    t_emit      emit;
    t_q_stat    qstat;

    assign fire    = r_in_valid && qstat.room;
    assign o_stall = r_in_valid && !qstat.room;
    assign in_acc  = i_valid && !o_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (in_acc) begin
            r_in_valid <= 1'b1;
        end else if (fire) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_in_byte <= i_in_byte;
            r_in_last <= i_is_last;
        end
    end

    jswcs_core u_core (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_fire  (fire),
        .i_byte  (r_in_byte),
        .i_last  (r_in_last),
        .o_emit  (emit)
    );

    jswcs_outq u_outq (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_push        (fire),
        .i_emit        (emit),
        .o_stat        (qstat),
        .o_valid       (o_valid),
        .i_stall       (i_stall),
        .o_out_byte    (o_out_byte),
        .o_last_of_run (o_last_of_run)
    );

`ifndef SYNTHESIS
    a_level_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        qstat.level <= QLW'(QDEPTH))
        else $error("result queue overflow");

    a_held_txn: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_in_valid && !qstat.room) |=> (r_in_valid && $stable(r_in_byte)))
        else $error("waiting transaction lost");

    a_reset_empty: assert property (@(posedge i_clk)
        $past(!i_rst_n) |-> (!o_valid && !r_in_valid))
        else $error("not empty after reset");
`endif

endmodule

`default_nettype wire

// ===== sim/jswcs_checker.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// jswcs_checker
// Watches both channels of the stripper, predicts the kept bytes of every
// accepted input transaction and compares each output transaction, in order,
// against the oldest expected byte. Reports the failure count and the number
// of bytes still expected.
// ----------------------------------------------------------------------------
module jswcs_checker
    import jswcs_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_src_valid,
    input  logic       i_src_stall,
    input  logic [7:0] i_src_byte,
    input  logic       i_src_last,
    input  logic       i_res_valid,
    input  logic       i_res_stall,
    input  logic [7:0] i_res_byte,
    input  logic       i_res_last,
    output int         o_err_count,
    output int         o_pending
);

    typedef enum logic [1:0] {
        SCAN_NORMAL  = 2'd0,
        SCAN_STRING  = 2'd1,
        SCAN_TRIM    = 2'd2,
        SCAN_COMMENT = 2'd3
    } t_scan;

    typedef struct packed {
        logic [7:0] chr;
        logic       last;
    } t_kept;

    t_scan      scan_mode_q;
    logic [7:0] open_quote;
    logic       esc_armed;
    logic       slash_held;
    t_kept      step_chars[$];
    t_kept      expected_chars[$];
    int         err_count = 0;

    assign o_err_count = err_count;

    function automatic logic is_blank(input logic [7:0] c);
        return c == CH_LF || c == CH_TAB || c == CH_CR || c == CH_SPACE;
    endfunction

    function automatic logic is_punct(input logic [7:0] c);
        return c == CH_SEMI || c == CH_LBRC || c == CH_RBRC || c == CH_LPAR ||
               c == CH_RPAR || c == CH_LBRK || c == CH_RBRK || c == CH_COMMA ||
               c == CH_DOT;
    endfunction

    task automatic clear_scan();
        scan_mode_q = SCAN_NORMAL;
        open_quote  = 8'h00;
        esc_armed   = 1'b0;
        slash_held  = 1'b0;
    endtask

    task automatic keep_char(input logic [7:0] c);
        if (step_chars.size() < 2) begin
            step_chars.push_back('{chr: c, last: 1'b0});
        end
    endtask

    task automatic scan_plain(input logic [7:0] c);
        if (c == CH_BSL) begin
            keep_char(c);
            esc_armed   = 1'b1;
            scan_mode_q = SCAN_NORMAL;
        end else if (c == CH_DQUOT || c == CH_SQUOT) begin
            keep_char(c);
            open_quote  = c;
            scan_mode_q = SCAN_STRING;
        end else if (c == CH_SLASH) begin
            slash_held  = 1'b1;
            scan_mode_q = SCAN_NORMAL;
        end else if (is_punct(c)) begin
            keep_char(c);
            scan_mode_q = SCAN_TRIM;
        end else begin
            keep_char(c);
            scan_mode_q = SCAN_NORMAL;
        end
    endtask

    task automatic strip_char(input logic [7:0] c, input logic last);
        t_kept tail;
        step_chars.delete();
        if (esc_armed) begin
            keep_char(c);
            esc_armed = 1'b0;
        end else begin
            case (scan_mode_q)
                SCAN_STRING: begin
                    keep_char(c);
                    if (c == CH_BSL) begin
                        esc_armed = 1'b1;
                    end else if (c == open_quote) begin
                        scan_mode_q = SCAN_NORMAL;
                        open_quote  = 8'h00;
                    end
                end
                SCAN_COMMENT: begin
                    if (c == CH_LF) scan_mode_q = SCAN_TRIM;
                end
                SCAN_TRIM: begin
                    if (!is_blank(c)) scan_plain(c);
                end
                default: begin
                    if (slash_held) begin
                        slash_held = 1'b0;
                        if (c == CH_SLASH) begin
                            scan_mode_q = SCAN_COMMENT;
                        end else begin
                            keep_char(CH_SLASH);
                            scan_plain(c);
                        end
                    end else begin
                        scan_plain(c);
                    end
                end
            endcase
        end
        if (last) begin
            if (slash_held) keep_char(CH_SLASH);
            clear_scan();
        end
        if (step_chars.size() > 0) begin
            tail      = step_chars.pop_back();
            tail.last = 1'b1;
            step_chars.push_back(tail);
        end
        foreach (step_chars[k]) expected_chars.push_back(step_chars[k]);
    endtask

    always @(posedge i_clk) begin
        t_kept want;
        if (!i_rst_n) begin
            clear_scan();
            expected_chars.delete();
        end else begin
            if (i_src_valid && !i_src_stall) strip_char(i_src_byte, i_src_last);
            if (i_res_valid && !i_res_stall) begin
                if (expected_chars.size() == 0) begin
                    $error("unexpected transaction: out_byte %h, last_of_run %b",
                           i_res_byte, i_res_last);
                    err_count++;
                end else begin
                    want = expected_chars.pop_front();
                    if (want.chr !== i_res_byte) begin
                        $error("out_byte: expected %h, actual %h", want.chr, i_res_byte);
                        err_count++;
                    end
                    if (want.last !== i_res_last) begin
                        $error("last_of_run: expected %b, actual %b", want.last, i_res_last);
                        err_count++;
                    end
                end
            end
        end
        o_pending = expected_chars.size();
    end

endmodule

// ===== sim/tb_js_whitespace_comment_stripper.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_js_whitespace_comment_stripper
// Drives the stripper with a directed script covering strings, escapes, line
// comments, held slashes, trimming after punctuation and stream ends, then a
// long run of randomly built script tokens mixed with noise bytes. Both sides
// idle at random; the checker does prediction and comparison.
// ----------------------------------------------------------------------------
module tb_js_whitespace_comment_stripper;
    import jswcs_pkg::*;

    localparam int CHAR_COUNT  = 1750;
    localparam int CYCLE_LIMIT = 400000;

    logic       clk = 1'b0;
    logic       rst_n;
    logic       in_valid;
    logic       in_stall;
    logic [7:0] in_byte;
    logic       in_last;
    logic       out_valid;
    logic       out_stall;
    logic [7:0] out_byte;
    logic       out_last;
    int         err_count;
    int         pending;
    int         cycle_count = 0;
    int         chars_sent = 0;
    bit         send_calm = 1'b0;

    js_whitespace_comment_stripper dut (
        .i_clk         (clk),
        .i_rst_n       (rst_n),
        .i_valid       (in_valid),
        .o_stall       (in_stall),
        .i_in_byte     (in_byte),
        .i_is_last     (in_last),
        .o_valid       (out_valid),
        .i_stall       (out_stall),
        .o_out_byte    (out_byte),
        .o_last_of_run (out_last)
    );

    jswcs_checker u_checker (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_src_valid (in_valid),
        .i_src_stall (in_stall),
        .i_src_byte  (in_byte),
        .i_src_last  (in_last),
        .i_res_valid (out_valid),
        .i_res_stall (out_stall),
        .i_res_byte  (out_byte),
        .i_res_last  (out_last),
        .o_err_count (err_count),
        .o_pending   (pending)
    );

    always begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    always @(posedge clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("FAILURE");
            $finish;
        end
    end

    // Called at a falling edge; returns at the falling edge after acceptance.
    task automatic send_char(input logic [7:0] c, input logic last);
        int gap;
        if ($urandom_range(0, 49) == 0) send_calm = !send_calm;
        gap = send_calm ? 0 : $urandom_range(0, 18);
        if (gap > 0) begin
            in_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        in_valid <= 1'b1;
        in_byte  <= c;
        in_last  <= last;
        do @(posedge clk); while (in_stall);
        @(negedge clk);
        chars_sent++;
    endtask

    task automatic feed_char(input logic [7:0] c);
        send_char(c, $urandom_range(0, 79) == 0);
    endtask

    task automatic wait_drained();
        in_valid <= 1'b0;
        do @(negedge clk); while (pending != 0);
    endtask

    function automatic logic [7:0] any_char();
        return 8'($urandom_range(1, 255));
    endfunction

    function automatic logic [7:0] blank_char();
        case ($urandom_range(0, 3))
            0:       return CH_SPACE;
            1:       return CH_TAB;
            2:       return CH_CR;
            default: return CH_LF;
        endcase
    endfunction

    function automatic logic [7:0] punct_char();
        case ($urandom_range(0, 8))
            0:       return CH_SEMI;
            1:       return CH_LBRC;
            2:       return CH_RBRC;
            3:       return CH_LPAR;
            4:       return CH_RPAR;
            5:       return CH_LBRK;
            6:       return CH_RBRK;
            7:       return CH_COMMA;
            default: return CH_DOT;
        endcase
    endfunction

    task automatic feed_token();
        int         pick;
        int         len;
        logic [7:0] c;
        logic [7:0] q;
        pick = $urandom_range(0, 99);
        if (pick < 20) begin
            len = $urandom_range(1, 6);
            repeat (len) feed_char(8'h61 + 8'($urandom_range(0, 25)));
        end else if (pick < 35) begin
            len = $urandom_range(1, 4);
            repeat (len) feed_char(blank_char());
        end else if (pick < 50) begin
            feed_char(punct_char());
        end else if (pick < 62) begin
            q = $urandom_range(0, 1) ? CH_DQUOT : CH_SQUOT;
            feed_char(q);
            len = $urandom_range(0, 6);
            repeat (len) begin
                if ($urandom_range(0, 4) == 0) begin
                    feed_char(CH_BSL);
                    feed_char(any_char());
                end else begin
                    feed_char(8'($urandom_range(32, 126)));
                end
            end
            feed_char(q);
        end else if (pick < 72) begin
            feed_char(CH_SLASH);
            feed_char(CH_SLASH);
            len = $urandom_range(0, 8);
            repeat (len) begin
                c = any_char();
                feed_char(c == CH_LF ? 8'h7A : c);
            end
            feed_char(CH_LF);
        end else if (pick < 78) begin
            feed_char(CH_SLASH);
        end else if (pick < 84) begin
            feed_char(CH_BSL);
            feed_char(any_char());
        end else begin
            len = $urandom_range(1, 3);
            repeat (len) feed_char(any_char());
        end
    endtask

    initial begin
        bit paused;
        paused   = 1'b0;
        rst_n    = 1'b0;
        in_valid = 1'b0;
        in_byte  = 8'h01;
        in_last  = 1'b0;
        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        send_char(8'h01, 1'b0);
        send_char(8'hFF, 1'b0);
        send_char(CH_SLASH, 1'b0);
        send_char(8'h61, 1'b0);
        send_char(CH_SEMI, 1'b0);
        send_char(CH_SPACE, 1'b0);
        send_char(CH_LF, 1'b0);
        send_char(8'h62, 1'b0);
        send_char(CH_DQUOT, 1'b0);
        send_char(CH_BSL, 1'b0);
        send_char(CH_DQUOT, 1'b0);
        send_char(CH_DQUOT, 1'b0);
        send_char(CH_SLASH, 1'b0);
        send_char(CH_SLASH, 1'b0);
        send_char(CH_BSL, 1'b0);
        send_char(CH_LF, 1'b0);
        send_char(CH_TAB, 1'b0);
        send_char(CH_SQUOT, 1'b0);
        send_char(8'h78, 1'b1);
        send_char(CH_SLASH, 1'b1);
        send_char(CH_BSL, 1'b0);
        send_char(CH_DQUOT, 1'b0);
        send_char(CH_SLASH, 1'b0);
        send_char(CH_SLASH, 1'b0);
        send_char(8'h63, 1'b1);
        wait_drained();

        while (chars_sent < CHAR_COUNT) begin
            if (!paused && chars_sent >= CHAR_COUNT / 2) begin
                wait_drained();
                paused = 1'b1;
            end
            feed_token();
        end
        wait_drained();
        repeat (20) @(negedge clk);

        if (err_count == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

    initial begin
        int hold;
        int taken;
        bit calm;
        taken     = 0;
        calm      = 1'b0;
        out_stall = 1'b0;
        @(posedge rst_n);
        forever begin
            @(negedge clk);
            if (taken == 250 || taken == 800) begin
                hold = 150;
            end else begin
                if ($urandom_range(0, 39) == 0) calm = !calm;
                hold = calm ? 0 : $urandom_range(0, 18);
            end
            if (hold > 0) begin
                out_stall <= 1'b1;
                repeat (hold) @(negedge clk);
                out_stall <= 1'b0;
            end
            do @(posedge clk); while (!(out_valid && !out_stall));
            taken++;
        end
    end

endmodule
